// ===== sv/tsr_pkg.sv =====
// ============================================================================
// tsr_pkg: shared types and constants of the TCP stream reassembler
// Sequencer states, shared adder commands and fixed limits.
// ============================================================================
package tsr_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int N_W         = 7;
	localparam int CNT_MAX     = 127;
	localparam int CAP_RESET   = 64;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EOF,
		ST_OFF,
		ST_PUT,
		ST_MARK,
		ST_RD,
		ST_CHK,
		ST_INC,
		ST_DIST,
		ST_EMPTY
	} tsr_state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} tsr_alu_op_t;

	typedef struct packed {
		tsr_alu_op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} tsr_alu_req_t;

endpackage

// ===== sv/tsr_ram.sv =====
// ============================================================================
// tsr_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ============================================================================
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/tsr_alu.sv =====
// ============================================================================
// tsr_alu: shared 32-bit add/subtract unit
// Serves eof position, window offset, index advance and eof distance.
// ============================================================================
module tsr_alu (
	input  tsr_pkg::tsr_alu_req_t req,
	output logic [31:0]           y
);

	always_comb begin
		unique case (req.op)
			tsr_pkg::ALU_ADD: begin
				y = req.a + req.b;
			end
			tsr_pkg::ALU_SUB: begin
				y = req.a - req.b;
			end
		endcase
	end

endmodule

// ===== sv/tcp_stream_reassembler.sv =====
// Sequence: an item passes the eof and offset states; a stored byte adds put and mark.
// A segment end adds read and check, then increment, distance and check per emitted
// byte; an empty run adds the empty state. Throughput: one item at a time.
// Reset: asynchronous, active low; afterwards a clearing pass over all WINDOW_DEPTH slots
// zeroes the slot valid RAM while item_stall stays high (config writes still taken).
// ============================================================================
// tcp_stream_reassembler: out-of-order byte stream reassembler
// Stores in-window bytes in a slot RAM and emits the in-order run at segment end.
// ============================================================================
module tcp_stream_reassembler #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        has_byte,
	input  logic [7:0]  byte_value,
	input  logic [31:0] byte_index,
	input  logic        segment_end,
	input  logic        eof,
	input  logic [6:0]  downstream_buffered,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        stream_closed,
	output logic [6:0]  unassembled_count,
	output logic        store_empty
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int HW = $clog2(WINDOW_DEPTH + 1);
	localparam int NW = tsr_pkg::N_W;

	tsr_pkg::tsr_state_t   state_q, state_d;
	tsr_pkg::tsr_alu_req_t alu_req;
	logic [31:0]           alu_y;

	logic [AW-1:0] clr_q, head_q, slot_q, off_q;
	logic [HW-1:0] held_q;
	logic [NW-1:0] n_q;
	logic [31:0]   ne_q, eofp_q;
	logic          eof_seen_q, closed_q;
	logic [6:0]    cap_q;

	logic          has_q, seg_q, eofi_q;
	logic [7:0]    val_q;
	logic [31:0]   idx_q;
	logic [6:0]    down_q;

	logic          pend_valid_q, pend_closed_q, pend_empty_q;
	logic [7:0]    pend_byte_q;
	logic [6:0]    pend_cnt_q;

	logic          res_valid_q, res_out_valid_q, res_last_q, res_closed_q, res_empty_q;
	logic [7:0]    res_byte_q;
	logic [6:0]    res_cnt_q;

	logic          vld_we, vld_wdata, vld_rdata;
	logic [AW-1:0] vld_waddr, vld_raddr;
	logic          dat_we;
	logic [7:0]    dat_rdata;

	logic          accept, eof_wr, off_ld, mark_inc, emit, fin_pend, fin_empty, inc_ne, dist_ld;
	logic          out_free, cond, in_win, reached;
	logic [6:0]    win_raw;
	logic [AW:0]   slot_sum, slot_wide;
	logic [AW-1:0] slot_nx, head_nx;
	logic [HW+6:0] held_ext;
	logic [6:0]    held_sat;

	tsr_alu u_alu (
		.req(alu_req),
		.y  (alu_y)
	);

	tsr_ram #(.WIDTH(1), .DEPTH(WINDOW_DEPTH)) u_vld_ram (
		.clk  (clk),
		.we   (vld_we),
		.waddr(vld_waddr),
		.wdata(vld_wdata),
		.raddr(vld_raddr),
		.rdata(vld_rdata)
	);

	tsr_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_dat_ram (
		.clk  (clk),
		.we   (dat_we),
		.waddr(slot_nx),
		.wdata(val_q),
		.raddr(head_q),
		.rdata(dat_rdata)
	);

	assign win_raw   = (cap_q > down_q) ? (cap_q - down_q) : 7'd0;
	assign in_win    = (alu_y < {25'd0, win_raw}) && (alu_y < 32'(WINDOW_DEPTH));
	assign slot_sum  = {1'b0, head_q} + {1'b0, off_q};
	assign slot_wide = (slot_sum >= (AW+1)'(WINDOW_DEPTH)) ?
		(slot_sum - (AW+1)'(WINDOW_DEPTH)) : slot_sum;
	assign slot_nx   = slot_wide[AW-1:0];
	assign head_nx   = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : (head_q + 1'b1);
	assign reached   = eof_seen_q && ((alu_y == 32'd0) || alu_y[31]);
	assign held_ext  = (HW+7)'(held_q);
	assign held_sat  = (held_ext > (HW+7)'(tsr_pkg::CNT_MAX)) ?
		7'(tsr_pkg::CNT_MAX) : held_ext[6:0];
	assign out_free  = !res_valid_q || !result_stall;
	assign cond      = vld_rdata && (n_q < NW'(tsr_pkg::MAX_RESULTS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsr_pkg::ST_CLEAR: begin
				if (clr_q == AW'(WINDOW_DEPTH - 1)) state_d = tsr_pkg::ST_IDLE;
			end
			tsr_pkg::ST_IDLE: begin
				if (item_valid) state_d = tsr_pkg::ST_EOF;
			end
			tsr_pkg::ST_EOF: begin
				state_d = tsr_pkg::ST_OFF;
			end
			tsr_pkg::ST_OFF: begin
				if (has_q && in_win) state_d = tsr_pkg::ST_PUT;
				else if (seg_q) state_d = tsr_pkg::ST_RD;
				else state_d = tsr_pkg::ST_IDLE;
			end
			tsr_pkg::ST_PUT: begin
				state_d = tsr_pkg::ST_MARK;
			end
			tsr_pkg::ST_MARK: begin
				state_d = seg_q ? tsr_pkg::ST_RD : tsr_pkg::ST_IDLE;
			end
			tsr_pkg::ST_RD: begin
				state_d = tsr_pkg::ST_CHK;
			end
			tsr_pkg::ST_CHK: begin
				if (cond) begin
					if (!pend_valid_q || out_free) state_d = tsr_pkg::ST_INC;
				end else if (pend_valid_q) begin
					if (out_free) state_d = tsr_pkg::ST_IDLE;
				end else begin
					state_d = tsr_pkg::ST_EMPTY;
				end
			end
			tsr_pkg::ST_INC: begin
				state_d = tsr_pkg::ST_DIST;
			end
			tsr_pkg::ST_DIST: begin
				state_d = tsr_pkg::ST_CHK;
			end
			tsr_pkg::ST_EMPTY: begin
				if (out_free) state_d = tsr_pkg::ST_IDLE;
			end
			default: begin
				state_d = tsr_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = 1'b1;
		alu_req    = '{op: tsr_pkg::ALU_ADD, a: ne_q, b: 32'd0};
		vld_we     = 1'b0;
		vld_waddr  = head_q;
		vld_wdata  = 1'b0;
		vld_raddr  = head_q;
		dat_we     = 1'b0;
		eof_wr     = 1'b0;
		off_ld     = 1'b0;
		mark_inc   = 1'b0;
		emit       = 1'b0;
		fin_pend   = 1'b0;
		fin_empty  = 1'b0;
		inc_ne     = 1'b0;
		dist_ld    = 1'b0;
		unique case (state_q)
			tsr_pkg::ST_CLEAR: begin
				vld_we    = 1'b1;
				vld_waddr = clr_q;
			end
			tsr_pkg::ST_IDLE: begin
				item_stall = 1'b0;
			end
			tsr_pkg::ST_EOF: begin
				alu_req = '{op: tsr_pkg::ALU_ADD, a: idx_q, b: {31'd0, has_q}};
				eof_wr  = eofi_q;
			end
			tsr_pkg::ST_OFF: begin
				alu_req = '{op: tsr_pkg::ALU_SUB, a: idx_q, b: ne_q};
				off_ld  = 1'b1;
			end
			tsr_pkg::ST_PUT: begin
				dat_we    = 1'b1;
				vld_raddr = slot_nx;
			end
			tsr_pkg::ST_MARK: begin
				vld_we    = 1'b1;
				vld_waddr = slot_q;
				vld_wdata = 1'b1;
				mark_inc  = !vld_rdata;
			end
			tsr_pkg::ST_RD: begin
			end
			tsr_pkg::ST_CHK: begin
				emit     = cond && (!pend_valid_q || out_free);
				fin_pend = !cond && pend_valid_q && out_free;
				vld_we   = emit;
			end
			tsr_pkg::ST_INC: begin
				alu_req = '{op: tsr_pkg::ALU_ADD, a: ne_q, b: 32'd1};
				inc_ne  = 1'b1;
			end
			tsr_pkg::ST_DIST: begin
				alu_req = '{op: tsr_pkg::ALU_SUB, a: eofp_q, b: ne_q};
				dist_ld = 1'b1;
			end
			tsr_pkg::ST_EMPTY: begin
				alu_req   = '{op: tsr_pkg::ALU_SUB, a: eofp_q, b: ne_q};
				fin_empty = out_free;
			end
			default: begin
			end
		endcase
	end

	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tsr_pkg::ST_CLEAR;
			clr_q        <= '0;
			head_q       <= '0;
			held_q       <= '0;
			n_q          <= '0;
			ne_q         <= '0;
			eof_seen_q   <= 1'b0;
			closed_q     <= 1'b0;
			cap_q        <= 7'(tsr_pkg::CAP_RESET);
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tsr_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (accept) n_q <= '0;
			if (eof_wr) eof_seen_q <= 1'b1;
			if (mark_inc) held_q <= held_q + 1'b1;
			if (emit) begin
				held_q       <= held_q - 1'b1;
				head_q       <= head_nx;
				n_q          <= n_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
			if (inc_ne) ne_q <= alu_y;
			if (fin_pend) begin
				pend_valid_q <= 1'b0;
				closed_q     <= pend_closed_q;
			end
			if (fin_empty) closed_q <= closed_q || reached;
			if ((emit && pend_valid_q) || fin_pend || fin_empty) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			has_q  <= has_byte;
			val_q  <= byte_value;
			idx_q  <= byte_index;
			seg_q  <= segment_end;
			eofi_q <= eof;
			down_q <= downstream_buffered;
		end
		if (eof_wr) eofp_q <= alu_y;
		if (off_ld) off_q <= alu_y[AW-1:0];
		if (state_q == tsr_pkg::ST_PUT) slot_q <= slot_nx;
		if (emit) pend_byte_q <= dat_rdata;
		if (dist_ld) begin
			pend_closed_q <= closed_q || reached;
			pend_cnt_q    <= held_sat;
			pend_empty_q  <= (held_q == '0);
		end
		if (fin_empty) begin
			res_out_valid_q <= 1'b0;
			res_byte_q      <= 8'd0;
			res_last_q      <= 1'b1;
			res_closed_q    <= closed_q || reached;
			res_cnt_q       <= held_sat;
			res_empty_q     <= (held_q == '0);
		end else if ((emit && pend_valid_q) || fin_pend) begin
			res_out_valid_q <= 1'b1;
			res_byte_q      <= pend_byte_q;
			res_last_q      <= fin_pend;
			res_closed_q    <= pend_closed_q;
			res_cnt_q       <= pend_cnt_q;
			res_empty_q     <= pend_empty_q;
		end
	end

	assign result_valid      = res_valid_q;
	assign out_valid         = res_out_valid_q;
	assign out_byte          = res_byte_q;
	assign run_last          = res_last_q;
	assign stream_closed     = res_closed_q;
	assign unassembled_count = res_cnt_q;
	assign store_empty       = res_empty_q;

endmodule

// ===== sv/tsr_checker.sv =====
// ============================================================================
// tsr_checker: port-level checks for the TCP stream reassembler
// Watches the result channel over time; bound to the top level.
// ============================================================================
module tsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        out_valid,
	input logic [7:0]  out_byte,
	input logic        run_last,
	input logic        stream_closed,
	input logic [6:0]  unassembled_count,
	input logic        store_empty
);

	// stalled transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) &&
		$stable(run_last) && $stable(unassembled_count))
		else $error("stalled result transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> store_empty == (unassembled_count == 7'd0))
		else $error("store_empty disagrees with count");

	// a run with no byte is always a single, last transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_valid |-> run_last && out_byte == 8'd0)
		else $error("empty result not marked last");

	// closed is sticky across back-to-back transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && stream_closed |=> !result_valid || stream_closed)
		else $error("stream reopened");

endmodule

bind tcp_stream_reassembler tsr_checker u_tsr_checker (.*);

// ===== bench/reassembly_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// reassembly_checker: expected-byte predictor and comparator for the reassembler
// Follows every accepted item and config write, keeps its own copy of the slot
// store, window and eof state, and compares each emitted result field by field.
// ============================================================================
module reassembly_checker #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        has_byte,
	input  logic [7:0]  byte_value,
	input  logic [31:0] byte_index,
	input  logic        segment_end,
	input  logic        eof,
	input  logic [6:0]  downstream_buffered,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        out_valid,
	input  logic [7:0]  out_byte,
	input  logic        run_last,
	input  logic        stream_closed,
	input  logic [6:0]  unassembled_count,
	input  logic        store_empty,
	output int          mismatch_count,
	output int          pending_emits,
	output logic [31:0] stream_pos
);

	typedef struct packed {
		logic                    out_valid;
		logic [7:0]              out_byte;
		logic                    run_last;
		logic                    stream_closed;
		logic [tsr_pkg::N_W-1:0] unassembled_count;
		logic                    store_empty;
	} emit_t;

	emit_t       emits_due[$];
	logic [7:0]  byte_mem[DEPTH];
	logic        slot_full[DEPTH];
	logic [31:0] next_idx;
	logic        eof_mark;
	logic [31:0] eof_at;
	logic        closed;
	logic [6:0]  capacity;
	int          held;
	int          head;

	function automatic bit eof_hit();
		logic [31:0] gap_to_eof;
		gap_to_eof = eof_at - next_idx;
		return eof_mark && (gap_to_eof == 32'd0 || gap_to_eof[31]);
	endfunction

	task automatic queue_emit(input logic valid, input logic [7:0] data, input logic last);
		emit_t e;
		int    cnt;
		cnt = (held > tsr_pkg::CNT_MAX) ? tsr_pkg::CNT_MAX : held;
		e.out_valid         = valid;
		e.out_byte          = data;
		e.run_last          = last;
		e.stream_closed     = closed || eof_hit();
		e.unassembled_count = cnt[tsr_pkg::N_W-1:0];
		e.store_empty       = (held == 0);
		emits_due.insert(emits_due.size(), e);
	endtask

	task automatic absorb_item();
		logic [31:0] room;
		logic [31:0] off;
		logic [7:0]  data;
		int          slot;
		int          n;
		if (eof) begin
			eof_mark = 1'b1;
			eof_at   = byte_index + 32'(has_byte);
		end
		if (has_byte) begin
			room = (capacity > downstream_buffered) ?
				32'(capacity - downstream_buffered) : 32'd0;
			if (room > DEPTH)
				room = DEPTH;
			off = byte_index - next_idx;
			if (off < room) begin
				slot = (head + int'(off)) % DEPTH;
				if (!slot_full[slot]) begin
					slot_full[slot] = 1'b1;
					held++;
				end
				byte_mem[slot] = byte_value;
			end
		end
		if (segment_end) begin
			n = 0;
			while (n < tsr_pkg::MAX_RESULTS && slot_full[head]) begin
				data            = byte_mem[head];
				slot_full[head] = 1'b0;
				held--;
				head = (head + 1) % DEPTH;
				next_idx++;
				n++;
				queue_emit(1'b1, data, n == tsr_pkg::MAX_RESULTS || !slot_full[head]);
			end
			if (eof_hit())
				closed = 1'b1;
			if (n == 0)
				queue_emit(1'b0, 8'd0, 1'b1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic compare_emit();
		emit_t want;
		if (emits_due.size() == 0) begin
			$display("%0t ns: result expected none, got valid %0d byte %0d last %0d",
				$time, out_valid, out_byte, run_last);
			mismatch_count++;
		end else begin
			want = emits_due.pop_front();
			check_field("out_valid", want.out_valid, out_valid);
			check_field("out_byte", want.out_byte, out_byte);
			check_field("run_last", want.run_last, run_last);
			check_field("stream_closed", want.stream_closed, stream_closed);
			check_field("unassembled_count", want.unassembled_count, unassembled_count);
			check_field("store_empty", want.store_empty, store_empty);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++)
				slot_full[k] = 1'b0;
			next_idx       = 32'd0;
			eof_mark       = 1'b0;
			eof_at         = 32'd0;
			closed         = 1'b0;
			capacity       = 7'(tsr_pkg::CAP_RESET);
			held           = 0;
			head           = 0;
			emits_due.delete();
			mismatch_count = 0;
			pending_emits  = 0;
			stream_pos     = 32'd0;
		end else begin
			if (result_valid && !result_stall)
				compare_emit();
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (item_valid && !item_stall)
				absorb_item();
			pending_emits = emits_due.size();
			stream_pos    = next_idx;
		end
	end

endmodule

// ===== bench/tcp_stream_reassembler_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tcp_stream_reassembler_tb: stimulus and verdict for the stream reassembler
// Drives directed and random segments (out of order, duplicated, dropped,
// empty and eof segments) under several window capacities with random sender
// gaps and receiver stalls; the checker module predicts and compares results.
// ============================================================================
module tcp_stream_reassembler_tb;

	localparam int WINDOW_DEPTH  = 64;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 20;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_HOLD,
		STALL_TOGGLE
	} stall_mode_t;

	logic        clk                 = 1'b0;
	logic        arst_n              = 1'b0;
	logic        cfg_wr_en           = 1'b0;
	logic [6:0]  cfg_wr_data         = 7'd0;
	logic        item_valid          = 1'b0;
	logic        item_stall;
	logic        has_byte            = 1'b0;
	logic [7:0]  byte_value          = 8'd0;
	logic [31:0] byte_index          = 32'd0;
	logic        segment_end         = 1'b0;
	logic        eof                 = 1'b0;
	logic [6:0]  downstream_buffered = 7'd0;
	logic        result_valid;
	logic        result_stall        = 1'b0;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        stream_closed;
	logic [6:0]  unassembled_count;
	logic        store_empty;

	int          mismatch_count;
	int          pending_emits;
	logic [31:0] stream_pos;

	int          burst_left   = 0;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          bytes_seen   = 0;
	int          quiet_cycles = 0;
	int          stall_left   = 0;
	stall_mode_t stall_mode   = STALL_NONE;

	tcp_stream_reassembler #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.has_byte           (has_byte),
		.byte_value         (byte_value),
		.byte_index         (byte_index),
		.segment_end        (segment_end),
		.eof                (eof),
		.downstream_buffered(downstream_buffered),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.out_valid          (out_valid),
		.out_byte           (out_byte),
		.run_last           (run_last),
		.stream_closed      (stream_closed),
		.unassembled_count  (unassembled_count),
		.store_empty        (store_empty)
	);

	reassembly_checker #(
		.DEPTH(WINDOW_DEPTH)
	) reasm_chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.has_byte           (has_byte),
		.byte_value         (byte_value),
		.byte_index         (byte_index),
		.segment_end        (segment_end),
		.eof                (eof),
		.downstream_buffered(downstream_buffered),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.out_valid          (out_valid),
		.out_byte           (out_byte),
		.run_last           (run_last),
		.stream_closed      (stream_closed),
		.unassembled_count  (unassembled_count),
		.store_empty        (store_empty),
		.mismatch_count     (mismatch_count),
		.pending_emits      (pending_emits),
		.stream_pos         (stream_pos)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12) :
				$urandom_range(8, 48);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: begin
				result_stall <= 1'b0;
			end
			STALL_COIN: begin
				result_stall <= 1'($urandom_range(0, 1));
			end
			STALL_HOLD: begin
				result_stall <= 1'b1;
			end
			default: begin
				result_stall <= ~result_stall;
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (out_valid)
					bytes_seen <= bytes_seen + 1;
			end
		end
	end

	function automatic logic [6:0] pick_down();
		int pick;
		pick = $urandom_range(0, 3);
		if (pick < 2)
			return 7'd0;
		else if (pick == 2)
			return 7'($urandom_range(0, 8));
		else
			return 7'($urandom_range(0, 64));
	endfunction

	task automatic send_item(input logic hb, input logic [7:0] val, input logic [31:0] idx,
			input logic se, input logic eo, input logic [6:0] dn);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_valid          <= 1'b1;
		has_byte            <= hb;
		byte_value          <= val;
		byte_index          <= idx;
		segment_end         <= se;
		eof                 <= eo;
		downstream_buffered <= dn;
		do @(posedge clk); while (item_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_segment(input logic [31:0] start, input int len, input bit mix,
			input logic [6:0] dn, input bit close_eof);
		int order[64];
		int j;
		int tmp;
		for (int k = 0; k < len; k++)
			order[k] = k;
		if (mix) begin
			for (int k = len - 1; k > 0; k--) begin
				j        = $urandom_range(0, k);
				tmp      = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
		end
		for (int k = 0; k < len; k++)
			send_item(1'b1, 8'($urandom), start + order[k], k == len - 1,
				close_eof && k == len - 1, dn);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending_emits != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [6:0] cap);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(input int n);
		int useful;
		int pick;
		int len;
		useful = 0;
		while (useful < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// in-order or ahead of a hole
				len = $urandom_range(1, 8);
				send_segment(stream_pos + (($urandom_range(0, 2) == 0) ?
					$urandom_range(1, 12) : 0), len, $urandom_range(0, 2) == 0,
					pick_down(), 1'b0);
				useful += len;
			end else if (pick < 75) begin
				// retransmission overlapping the emitted point
				len = $urandom_range(2, 8);
				send_segment(stream_pos - $urandom_range(1, 6), len, 1'b1, pick_down(), 1'b0);
				useful += len;
			end else if (pick < 87) begin
				send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom,
					1'($urandom_range(0, 1)), 1'b0, pick_down());
			end else if (pick < 95) begin
				send_item(1'b0, 8'($urandom), stream_pos, 1'b1, 1'b0, pick_down());
				useful++;
			end else begin
				// eof far ahead keeps the stream open
				send_item(1'b0, 8'($urandom), stream_pos + $urandom_range(1000, 1 << 20),
					1'($urandom_range(0, 1)), 1'b1, pick_down());
				useful++;
			end
		end
	endtask

	initial begin
		int cap_mid;
		cap_mid = $urandom_range(2, 63);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_capacity(7'(tsr_pkg::CAP_RESET));

		send_item(1'b0, 8'h00, 32'd0, 1'b1, 1'b0, 7'd0);
		send_item(1'b0, 8'h00, 32'd0, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'hFF, 32'd1, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'h00, 32'd0, 1'b1, 1'b0, 7'd0);
		send_item(1'b1, 8'h11, 32'd3, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'hEE, 32'd3, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'h5A, 32'd2, 1'b1, 1'b0, 7'd0);
		send_item(1'b1, 8'hA5, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0);
		send_item(1'b1, 8'h3C, 32'd4, 1'b1, 1'b0, 7'd64);
		send_item(1'b0, 8'h00, 32'd1000, 1'b1, 1'b1, 7'd0);
		send_item(1'b1, 8'h80, 32'd67, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'h81, 32'd68, 1'b0, 1'b0, 7'd0);
		send_item(1'b1, 8'h42, 32'd4, 1'b1, 1'b0, 7'd0);
		send_item(1'b1, 8'h77, 32'd5, 1'b0, 1'b0, 7'd60);
		send_item(1'b1, 8'h99, 32'd9, 1'b1, 1'b0, 7'd60);
		send_item(1'b1, 8'hC3, 32'h7000_0000, 1'b1, 1'b1, 7'd0);
		send_item(1'b1, 8'h01, 32'd7, 1'b0, 1'b0, 7'd0);
		send_item(1'b0, 8'h00, 32'd6, 1'b1, 1'b0, 7'd0);
		send_item(1'b1, 8'h02, 32'd6, 1'b1, 1'b0, 7'd0);
		settle();

		set_capacity(7'd1);
		random_phase(8);
		settle();

		set_capacity(7'(cap_mid));
		random_phase(12);
		settle();

		set_capacity(7'd64);
		random_phase(6);
		// hold off until every result has drained
		settle();
		send_segment(stream_pos, WINDOW_DEPTH, 1'b1, 7'd0, 1'b0);
		random_phase(6);
		settle();

		send_segment(stream_pos, 3, 1'b0, 7'd0, 1'b1);
		send_item(1'b0, 8'h00, stream_pos, 1'b1, 1'b0, 7'd0);
		send_item(1'b0, 8'h00, stream_pos + 5000, 1'b1, 1'b1, 7'd0);
		settle();

		$display("Sent %0d items, took %0d results (%0d assembled bytes).",
			items_sent, results_seen, bytes_seen);
		$display("Capacities 64, 1, %0d, 64; holes, retransmits, drops, eof, full run, close.",
			cap_mid);
		if (mismatch_count == 0 && pending_emits == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tsr_pkg.sv
sv/tsr_ram.sv
sv/tsr_alu.sv
sv/tcp_stream_reassembler.sv
sv/tsr_checker.sv
bench/reassembly_checker.sv
bench/tcp_stream_reassembler_tb.sv
